[rtl/useg_pkg.sv]
// useg_pkg: shared types, codes and widths of the utterance segmenter
// no dependencies; compile first
package useg_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  // event codes carried on the input channel
  typedef enum logic [CMD_W-1:0] {
    CMD_SPEECH_START  = 3'd0,
    CMD_SPEECH_ACTIVE = 3'd1,
    CMD_SPEECH_END    = 3'd2,
    CMD_SILENCE       = 3'd3,
    CMD_FRAME_TICK    = 3'd4,
    CMD_CHUNK_DONE    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_STREAM = 2'd1,
    PH_POST   = 2'd2
  } phase_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POST_ROLL   = 1'b0,
    CFG_UPLOADER_EN = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] utt_count;
    logic [CNT_W-1:0] chunk_count;
    logic [CNT_W-1:0] duration;
    logic [MS_W-1:0]  post_left;
  } state_t;

  typedef struct packed {
    logic             ok;
    phase_t           phase;
    logic             started;
    logic             ended;
    logic [CNT_W-1:0] utterance_number;
    logic [CNT_W-1:0] chunks;
    logic [CNT_W-1:0] utt_duration;
    logic             upload_active;
  } result_t;

endpackage

[rtl/useg_if.sv]
// useg channel interfaces: input events, results and configuration writes
// depends on useg_pkg for field widths
interface useg_in_if;
  logic                          valid;
  logic                          ready;
  logic [useg_pkg::CMD_W-1:0]    cmd;
  logic [useg_pkg::MS_W-1:0]     frame_ms;
  logic                          start_ok;

  modport source (output valid, cmd, frame_ms, start_ok, input ready);
  modport sink   (input valid, cmd, frame_ms, start_ok, output ready);
endinterface

interface useg_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [1:0]                    phase;
  logic                          started;
  logic                          ended;
  logic [useg_pkg::CNT_W-1:0]    utterance_number;
  logic [useg_pkg::CNT_W-1:0]    chunks;
  logic [useg_pkg::CNT_W-1:0]    utt_duration;
  logic                          upload_active;

  modport source (output valid, ok, phase, started, ended, utterance_number, chunks,
                  utt_duration, upload_active, input ready);
  modport sink   (input valid, ok, phase, started, ended, utterance_number, chunks,
                  utt_duration, upload_active, output ready);
endinterface

interface useg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [useg_pkg::CFG_IDX_W-1:0]    index;
  logic [useg_pkg::CFG_DAT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/useg_step.sv]
// useg_step: next-state and result logic for one event
// depends on useg_pkg
module useg_step (
  input  useg_pkg::state_t               st,
  input  logic [useg_pkg::CMD_W-1:0]     cmd,
  input  logic [useg_pkg::MS_W-1:0]      frame_ms,
  input  logic                           start_ok,
  input  logic [useg_pkg::MS_W-1:0]      post_roll_ms,
  input  logic                           uploader_en,
  output useg_pkg::state_t               st_nxt,
  output useg_pkg::result_t              res
);
  import useg_pkg::*;

  logic             ok;
  logic             started;
  logic             ended;
  logic [CNT_W-1:0] dur_sum;

  assign dur_sum = st.duration + {{(CNT_W-MS_W){1'b0}}, frame_ms};

  always_comb begin
    st_nxt  = st;
    ok      = 1'b1;
    started = 1'b0;
    ended   = 1'b0;
    case (cmd_t'(cmd))
      CMD_SPEECH_START: begin
        if (st.phase == PH_IDLE) begin
          if (!uploader_en) begin
            ok = 1'b0;
          end else begin
            st_nxt.utt_count   = st.utt_count + CNT_W'(1);
            st_nxt.chunk_count = '0;
            st_nxt.duration    = '0;
            st_nxt.post_left   = '0;
            if (start_ok) begin
              st_nxt.phase = PH_STREAM;
              started      = 1'b1;
            end else begin
              ok = 1'b0;
            end
          end
        end else if (st.phase == PH_POST) begin
          st_nxt.phase     = PH_STREAM;
          st_nxt.post_left = '0;
        end
      end
      CMD_SPEECH_ACTIVE: begin
        if (st.phase == PH_STREAM) st_nxt.duration = dur_sum;
      end
      CMD_SPEECH_END: begin
        if (st.phase == PH_STREAM) begin
          if (post_roll_ms == '0) begin
            st_nxt.phase     = PH_IDLE;
            st_nxt.post_left = '0;
            ended            = uploader_en;
            ok               = uploader_en;
          end else begin
            st_nxt.phase     = PH_POST;
            st_nxt.post_left = post_roll_ms;
          end
        end
      end
      CMD_FRAME_TICK: begin
        if (st.phase == PH_POST) begin
          st_nxt.duration = dur_sum;
          if (st.post_left <= frame_ms) begin
            st_nxt.phase     = PH_IDLE;
            st_nxt.post_left = '0;
            ended            = uploader_en;
          end else begin
            st_nxt.post_left = st.post_left - frame_ms;
          end
        end
      end
      CMD_CHUNK_DONE: begin
        if (st.phase inside {PH_STREAM, PH_POST})
          st_nxt.chunk_count = st.chunk_count + CNT_W'(1);
      end
      default: begin
        // silence and unused codes leave the state alone
      end
    endcase
  end

  always_comb begin
    res.ok               = ok;
    res.phase            = st_nxt.phase;
    res.started          = started;
    res.ended            = ended;
    res.utterance_number = st_nxt.utt_count;
    res.chunks           = st_nxt.chunk_count;
    res.utt_duration     = st_nxt.duration;
    res.upload_active    = (st_nxt.phase == PH_STREAM) || (st_nxt.phase == PH_POST);
  end

endmodule

[rtl/utterance_segmenter.sv]
// utterance_segmenter: top level, input register, state, result register
// depends on useg_pkg, useg_if and useg_step
//
// Turns a stream of voice-activity events into numbered utterances. Every
// accepted event yields exactly one result: whether it succeeded, the phase
// after the event (idle, streaming, post-roll), start and end strobes, and
// the number, chunk count and duration of the current or last utterance.
// An event is taken in every cycle when the result side keeps up; its result
// is presented on the result channel once the event has passed through the
// input register and the step logic has loaded the result register, and the
// combinational step logic updates the segmenter state in place, so
// consecutive events see each other's effects with no gap.
// A stalled result holds the pipeline and drops in_ch.ready only once both
// registers are full. Configuration writes are always taken (cfg_ch.ready is
// tied high) and should be made while no event is in flight. Counters wrap
// modulo 2^32.
module utterance_segmenter (
  input logic       clk,
  input logic       rst_n,
  useg_in_if.sink   in_ch,
  useg_out_if.source out_ch,
  useg_cfg_if.sink  cfg_ch
);
  import useg_pkg::*;

  // configuration registers
  logic [MS_W-1:0]  post_roll_r;
  logic             upl_en_r;

  // input register
  logic             s1_valid_r;
  logic [CMD_W-1:0] s1_cmd_r;
  logic [MS_W-1:0]  s1_fms_r;
  logic             s1_sok_r;

  // segmenter state and result register
  state_t           st_r;
  state_t           st_nxt;
  result_t          res_nxt;
  result_t          res_r;
  logic             out_valid_r;

  logic             advance;
  logic             in_xfer;

  // the result register can take a new value when empty or being drained
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_roll_r <= '0;
      upl_en_r    <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_POST_ROLL:   post_roll_r <= cfg_ch.data;
        CFG_UPLOADER_EN: upl_en_r    <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

  // input register: holds one event until the step logic consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r <= in_ch.cmd;
      s1_fms_r <= in_ch.frame_ms;
      s1_sok_r <= in_ch.start_ok;
    end
  end

  useg_step u_step (
    .st           (st_r),
    .cmd          (s1_cmd_r),
    .frame_ms     (s1_fms_r),
    .start_ok     (s1_sok_r),
    .post_roll_ms (post_roll_r),
    .uploader_en  (upl_en_r),
    .st_nxt       (st_nxt),
    .res          (res_nxt)
  );

  // state commits in the same cycle that the result is registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= PH_IDLE;
      st_r.utt_count   <= '0;
      st_r.chunk_count <= '0;
      st_r.duration    <= '0;
      st_r.post_left   <= '0;
      out_valid_r      <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) res_r <= res_nxt;
  end

  // result channel
  assign out_ch.valid            = out_valid_r;
  assign out_ch.ok               = res_r.ok;
  assign out_ch.phase            = res_r.phase;
  assign out_ch.started          = res_r.started;
  assign out_ch.ended            = res_r.ended;
  assign out_ch.utterance_number = res_r.utterance_number;
  assign out_ch.chunks           = res_r.chunks;
  assign out_ch.utt_duration     = res_r.utt_duration;
  assign out_ch.upload_active    = res_r.upload_active;

endmodule

[rtl/useg_checker.sv]
// useg_checker: port-level assertions for the utterance segmenter
// depends on useg_pkg; bound to utterance_segmenter below
module useg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_ok,
  input logic [1:0]                    out_phase,
  input logic                          out_started,
  input logic                          out_ended,
  input logic                          out_upload_active,
  input logic [useg_pkg::CNT_W-1:0]    out_utterance_number
);
  import useg_pkg::*;

  // nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a started utterance is streaming and successful
  a_start_streams: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_started) |->
      (out_phase == PH_STREAM && out_upload_active && out_ok && !out_ended))
    else $error("start strobe without streaming phase");

  // a finalize always leaves the block idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ended) |-> (out_phase == PH_IDLE && !out_upload_active))
    else $error("end strobe outside idle phase");

  // a stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_phase) && $stable(out_utterance_number)))
    else $error("result changed while stalled");

endmodule

bind utterance_segmenter useg_checker u_useg_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_ok               (out_ch.ok),
  .out_phase            (out_ch.phase),
  .out_started          (out_ch.started),
  .out_ended            (out_ch.ended),
  .out_upload_active    (out_ch.upload_active),
  .out_utterance_number (out_ch.utterance_number)
);
